// ===== hdl/shc_pkg.sv =====
// Package for the staged heater controller: types, register indexes and constants.
`default_nettype none

package shc_pkg;

   localparam int unsigned CsrIndexWidth = 3;
   localparam int unsigned CsrDataWidth = 32;

   localparam int unsigned NotReceivedCodeDefault = 255;
   localparam int unsigned RampStepDefault = 10;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_ENABLE_DELAY      = 3'd0,
      CSR_MIN_FAN_SPEED     = 3'd1,
      CSR_MIN_BATTERY       = 3'd2,
      CSR_MIN_SETPOINTS     = 3'd3,
      CSR_DEFROST_SETPOINTS = 3'd4,
      CSR_OUTDOOR_LIMITS    = 3'd5,
      CSR_COOLANT_ON        = 3'd6,
      CSR_COOLANT_OFF       = 3'd7
   } shc_csr_index_type;

   localparam logic [1:0] LEVEL_OFF  = 2'd0;
   localparam logic [1:0] LEVEL_LOW  = 2'd1;
   localparam logic [1:0] LEVEL_MED  = 2'd2;
   localparam logic [1:0] LEVEL_FULL = 2'd3;

   typedef struct packed {
      logic [15:0] enable_delay_s;
      logic [7:0]  min_fan_speed;
      logic [7:0]  min_battery_code;
      logic [15:0] min_cabin_setpoints;
      logic [15:0] defrost_cabin_setpoints;
      logic [31:0] outdoor_limits;
      logic [31:0] coolant_on_limits;
      logic [31:0] coolant_off_limits;
   } shc_cfg_type;

   typedef struct packed {
      logic [15:0]        seconds_since_start;
      logic signed [7:0]  coolant_temp;
      logic signed [7:0]  outdoor_temp;
      logic [7:0]         battery_code;
      logic [7:0]         fan_speed;
      logic signed [7:0]  left_setpoint;
      logic signed [7:0]  right_setpoint;
      logic               windshield_blowing;
      logic               recirculation_on;
      logic               emergency_stop;
   } shc_req_type;

endpackage

`default_nettype wire

// ===== hdl/shc_req_if.sv =====
// Request channel interface: one control tick of vehicle readings.
`default_nettype none

interface shc_req_if;
   logic               valid;
   logic               ready;
   logic [15:0]        seconds_since_start;
   logic signed [7:0]  coolant_temp;
   logic signed [7:0]  outdoor_temp;
   logic [7:0]         battery_code;
   logic [7:0]         fan_speed;
   logic signed [7:0]  left_setpoint;
   logic signed [7:0]  right_setpoint;
   logic               windshield_blowing;
   logic               recirculation_on;
   logic               emergency_stop;

   modport source (
      output valid, seconds_since_start, coolant_temp, outdoor_temp, battery_code,
             fan_speed, left_setpoint, right_setpoint, windshield_blowing,
             recirculation_on, emergency_stop,
      input  ready
   );

   modport sink (
      input  valid, seconds_since_start, coolant_temp, outdoor_temp, battery_code,
             fan_speed, left_setpoint, right_setpoint, windshield_blowing,
             recirculation_on, emergency_stop,
      output ready
   );
endinterface

`default_nettype wire

// ===== hdl/shc_rsp_if.sv =====
// Response channel interface: power level and heater status per tick.
`default_nettype none

interface shc_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] power_level;
   logic       heating_active;
   logic       heat_requested;

   modport source (
      output valid, power_level, heating_active, heat_requested,
      input  ready
   );

   modport sink (
      input  valid, power_level, heating_active, heat_requested,
      output ready
   );
endinterface

`default_nettype wire

// ===== hdl/shc_csr.sv =====
// Configuration register file of the staged heater controller.
`default_nettype none

module shc_csr (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_wr_en,
   input  wire logic [shc_pkg::CsrIndexWidth-1:0]   csr_index,
   input  wire logic [shc_pkg::CsrDataWidth-1:0]    csr_wdata,
   output shc_pkg::shc_cfg_type                     cfg
);

   shc_pkg::shc_cfg_type cfg_ff;
   shc_pkg::shc_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (shc_pkg::shc_csr_index_type'(csr_index))
            shc_pkg::CSR_ENABLE_DELAY:      cfg_in.enable_delay_s = csr_wdata[15:0];
            shc_pkg::CSR_MIN_FAN_SPEED:     cfg_in.min_fan_speed = csr_wdata[7:0];
            shc_pkg::CSR_MIN_BATTERY:       cfg_in.min_battery_code = csr_wdata[7:0];
            shc_pkg::CSR_MIN_SETPOINTS:     cfg_in.min_cabin_setpoints = csr_wdata[15:0];
            shc_pkg::CSR_DEFROST_SETPOINTS: cfg_in.defrost_cabin_setpoints = csr_wdata[15:0];
            shc_pkg::CSR_OUTDOOR_LIMITS:    cfg_in.outdoor_limits = csr_wdata[31:0];
            shc_pkg::CSR_COOLANT_ON:        cfg_in.coolant_on_limits = csr_wdata[31:0];
            shc_pkg::CSR_COOLANT_OFF:       cfg_in.coolant_off_limits = csr_wdata[31:0];
            default:                        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== hdl/shc_in_stage.sv =====
// Input register stage: captures one request transaction per cycle unless it holds an item that has not advanced.
`default_nettype none

module shc_in_stage (
   input  wire logic            clock,
   input  wire logic            reset,
   shc_req_if.sink              req_chan,
   input  wire logic            advance,
   output logic                 item_valid,
   output shc_pkg::shc_req_type item
);

   logic                 valid_ff;
   logic                 valid_in;
   logic                 accept;
   shc_pkg::shc_req_type item_ff;

   assign req_chan.ready = !valid_ff || advance;
   assign accept = req_chan.valid && req_chan.ready;
   assign valid_in = accept || (valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.seconds_since_start <= req_chan.seconds_since_start;
         item_ff.coolant_temp        <= req_chan.coolant_temp;
         item_ff.outdoor_temp        <= req_chan.outdoor_temp;
         item_ff.battery_code        <= req_chan.battery_code;
         item_ff.fan_speed           <= req_chan.fan_speed;
         item_ff.left_setpoint       <= req_chan.left_setpoint;
         item_ff.right_setpoint      <= req_chan.right_setpoint;
         item_ff.windshield_blowing  <= req_chan.windshield_blowing;
         item_ff.recirculation_on    <= req_chan.recirculation_on;
         item_ff.emergency_stop      <= req_chan.emergency_stop;
      end
   end

   assign item_valid = valid_ff;
   assign item = item_ff;

endmodule

`default_nettype wire

// ===== hdl/shc_ctrl.sv =====
// Heat request decision, power ramp state and response register.
`default_nettype none

module shc_ctrl #(
   parameter int unsigned NOT_RECEIVED_CODE = shc_pkg::NotReceivedCodeDefault,
   parameter int unsigned RAMP_STEP_S       = shc_pkg::RampStepDefault
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire shc_pkg::shc_cfg_type  cfg,
   input  wire logic                  item_valid,
   input  wire shc_pkg::shc_req_type  item,
   output logic                       advance,
   shc_rsp_if.source                  rsp_chan
);

   localparam logic [7:0]  NrCode   = 8'(NOT_RECEIVED_CODE);
   localparam logic [15:0] StepOne  = 16'(RAMP_STEP_S);
   localparam logic [15:0] StepTwo  = 16'(2 * RAMP_STEP_S);

   logic        heat_request_ff, heat_request_in;
   logic        applied_request_ff, applied_request_in;
   logic        heating_mode_ff, heating_mode_in;
   logic [15:0] change_time_ff, change_time_in;
   logic [1:0]  level_ff, level_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  power_level_ff, power_level_in;
   logic        heating_active_ff;
   logic        heat_requested_ff;

   logic        fire;
   logic        received;
   logic        enabled;
   logic        vehicle_ready;
   logic        defrost;
   logic        must_on;
   logic        must_off;
   logic [15:0] elapsed;

   assign advance = !rsp_valid_ff || rsp_chan.ready;
   assign fire = item_valid && advance;

   always_comb begin
      received = (item.coolant_temp != NrCode) && (item.outdoor_temp != NrCode) &&
                 (item.battery_code != NrCode) && (item.fan_speed != NrCode) &&
                 (item.left_setpoint != NrCode) && (item.right_setpoint != NrCode);
      enabled = !item.emergency_stop && (item.seconds_since_start > cfg.enable_delay_s) &&
                received;

      vehicle_ready = (item.fan_speed >= cfg.min_fan_speed) &&
                      (item.battery_code >= cfg.min_battery_code) &&
                      (item.left_setpoint >= $signed(cfg.min_cabin_setpoints[7:0])) &&
                      (item.right_setpoint >= $signed(cfg.min_cabin_setpoints[15:8]));

      defrost = item.windshield_blowing &&
                (item.left_setpoint > $signed(cfg.defrost_cabin_setpoints[7:0])) &&
                (item.right_setpoint > $signed(cfg.defrost_cabin_setpoints[15:8])) &&
                (item.fan_speed >= cfg.min_fan_speed) && !item.recirculation_on;
   end

   // threshold rows: independent compares, OR-reduced
   always_comb begin
      must_on  = 1'b0;
      must_off = 1'b0;
      for (int r = 0; r < 4; r++) begin
         if (item.outdoor_temp <= $signed(cfg.outdoor_limits[8*r +: 8])) begin
            if (item.coolant_temp < $signed(cfg.coolant_on_limits[8*r +: 8])) begin
               must_on = 1'b1;
            end
            if (item.coolant_temp >= $signed(cfg.coolant_off_limits[8*r +: 8])) begin
               must_off = 1'b1;
            end
         end
      end
   end

   always_comb begin
      heat_request_in    = heat_request_ff;
      applied_request_in = applied_request_ff;
      heating_mode_in    = heating_mode_ff;
      change_time_in     = change_time_ff;
      level_in           = level_ff;
      elapsed            = '0;

      if (enabled) begin
         if (vehicle_ready) begin
            if (!heating_mode_ff && must_on) begin
               heat_request_in = 1'b1;
            end else if (heating_mode_ff && must_off) begin
               heat_request_in = 1'b0;
            end
         end else begin
            heat_request_in = defrost;
         end

         applied_request_in = heat_request_in;
         if (applied_request_ff != heat_request_in) begin
            change_time_in = item.seconds_since_start;
         end

         elapsed = item.seconds_since_start - change_time_in;

         if (applied_request_in) begin
            heating_mode_in = 1'b1;
            if (elapsed <= StepOne) begin
               level_in = shc_pkg::LEVEL_LOW;
            end else if (elapsed <= StepTwo) begin
               level_in = shc_pkg::LEVEL_MED;
            end else begin
               level_in = shc_pkg::LEVEL_FULL;
            end
         end else if (heating_mode_ff) begin
            if (elapsed <= StepOne) begin
               level_in = shc_pkg::LEVEL_MED;
            end else if (elapsed <= StepTwo) begin
               level_in = shc_pkg::LEVEL_LOW;
            end else begin
               level_in = shc_pkg::LEVEL_OFF;
               heating_mode_in = 1'b0;
            end
         end else begin
            level_in = shc_pkg::LEVEL_OFF;
         end
      end

      power_level_in = item.emergency_stop ? shc_pkg::LEVEL_OFF : level_in;
      rsp_valid_in   = fire || (rsp_valid_ff && !rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         heat_request_ff    <= 1'b0;
         applied_request_ff <= 1'b0;
         heating_mode_ff    <= 1'b0;
         change_time_ff     <= '0;
         level_ff           <= shc_pkg::LEVEL_OFF;
         rsp_valid_ff       <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            heat_request_ff    <= heat_request_in;
            applied_request_ff <= applied_request_in;
            heating_mode_ff    <= heating_mode_in;
            change_time_ff     <= change_time_in;
            level_ff           <= level_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         power_level_ff    <= power_level_in;
         heating_active_ff <= heating_mode_in;
         heat_requested_ff <= heat_request_in;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.power_level    = power_level_ff;
   assign rsp_chan.heating_active = heating_active_ff;
   assign rsp_chan.heat_requested = heat_requested_ff;

endmodule

`default_nettype wire

// ===== hdl/staged_heater_controller.sv =====
// Staged heater controller top level.
//
// One request transaction is one control tick: seconds since engine start and
// the vehicle readings. Each tick yields exactly one response transaction with
// the power level (0..3) and the heating and request flags after that tick.
// Thresholds and limits are written through the csr_ port (index, data,
// write enable); write them only while no transaction is in flight.
// A tick is captured in the input register, then passes through the decision
// logic into the response register.
// Throughput: one tick per cycle unless stalled; the ramp state is updated
// in the same cycle the response register loads, so consecutive ticks see
// each other's state. When the receiver stalls, the response holds, the input
// register holds one more tick, and req_chan.ready drops once both are full.
// Reset (synchronous) clears the configuration, the heat state and the ramp,
// and drops both valids; the data registers are not cleared.
`default_nettype none

module staged_heater_controller #(
   parameter int unsigned NOT_RECEIVED_CODE = shc_pkg::NotReceivedCodeDefault,
   parameter int unsigned RAMP_STEP_S       = shc_pkg::RampStepDefault
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   shc_req_if.sink                                  req_chan,
   shc_rsp_if.source                                rsp_chan,
   input  wire logic                                csr_wr_en,
   input  wire logic [shc_pkg::CsrIndexWidth-1:0]   csr_index,
   input  wire logic [shc_pkg::CsrDataWidth-1:0]    csr_wdata
);

   shc_pkg::shc_cfg_type cfg;
   shc_pkg::shc_req_type item;
   logic                 item_valid;
   logic                 advance;

   shc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   shc_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   shc_ctrl #(
      .NOT_RECEIVED_CODE (NOT_RECEIVED_CODE),
      .RAMP_STEP_S       (RAMP_STEP_S)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .item_valid (item_valid),
      .item       (item),
      .advance    (advance),
      .rsp_chan   (rsp_chan)
   );

endmodule

`default_nettype wire
